/* src/pmul_pkg.sv */
// shared types and constants for the polynomial multiplier
// used by pmul_ctrl, pmul_dp and polynomial_multiply; no dependencies
package pmul_pkg;

    localparam int DEF_MAX_TERMS   = 16;
    localparam int DEF_COEFF_WIDTH = 32;
    localparam int FRAC_BITS       = 16;

    // fixed field widths on the stream ports
    localparam int DATA_W      = 32;
    localparam int TERM_W      = 5;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - TERM_W;

    // operand select carried on the input tuser
    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SETUP,
        ST_MAC,
        ST_WAIT,
        ST_OUT
    } pmul_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd;
        logic first;
        logic last;
        logic load_zero;
    } pmul_cmd_t;

endpackage

/* src/pmul_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module pmul_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pmul_dp.sv */
// datapath: operand stores, multiplier, accumulator, shift and saturation
// depends on pmul_pkg and pmul_ram
module pmul_dp #(
    parameter int MAX_TERMS   = pmul_pkg::DEF_MAX_TERMS,
    parameter int COEFF_WIDTH = pmul_pkg::DEF_COEFF_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pmul_pkg::pmul_cmd_t          cmd,
    input  logic [$clog2(MAX_TERMS)-1:0] wr_addr,
    input  logic [$clog2(MAX_TERMS)-1:0] rd_addr_a,
    input  logic [$clog2(MAX_TERMS)-1:0] rd_addr_b,
    input  logic [COEFF_WIDTH-1:0]       wr_data,
    output logic                         term_done,
    output logic [pmul_pkg::DATA_W-1:0]  product_coefficient
);

    import pmul_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int PROD_W = 2 * COEFF_WIDTH;
    localparam int ACC_W = PROD_W + CNT_W;

    logic [COEFF_WIDTH-1:0]        a_data;
    logic [COEFF_WIDTH-1:0]        b_data;
    logic                          v1_reg, first1_reg, last1_reg;
    logic                          v2_reg, first2_reg, last2_reg;
    logic                          done3_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       shifted;
    logic [ACC_W-COEFF_WIDTH:0]    upper;
    logic                          in_range;
    logic signed [COEFF_WIDTH-1:0] sat_value;
    logic signed [COEFF_WIDTH-1:0] out_reg;

    pmul_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(MAX_TERMS)) u_ram_a (
        .aclk  (aclk),
        .we    (cmd.wr_a),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr_a),
        .rdata (a_data)
    );

    pmul_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(MAX_TERMS)) u_ram_b (
        .aclk  (aclk),
        .we    (cmd.wr_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr_b),
        .rdata (b_data)
    );

    always_comb begin
        if (first2_reg) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor shift, then clamp to the signed coefficient range
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign upper    = shifted[ACC_W-1:COEFF_WIDTH-1];
    assign in_range = (&upper) | ~(|upper);

    always_comb begin
        if (in_range) begin
            sat_value = shifted[COEFF_WIDTH-1:0];
        end else if (shifted[ACC_W-1]) begin
            sat_value = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done3_reg <= 1'b0;
        end else begin
            v1_reg    <= cmd.rd;
            v2_reg    <= v1_reg;
            done3_reg <= v2_reg & last2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        prod_reg   <= signed'(a_data) * signed'(b_data);
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.load_zero) begin
            out_reg <= '0;
        end else if (done3_reg) begin
            out_reg <= sat_value;
        end
    end

    assign term_done           = done3_reg;
    assign product_coefficient = DATA_W'(out_reg);

endmodule

/* src/pmul_ctrl.sv */
// controller: operand counts, term and pair sequencing, output handshake
// depends on pmul_pkg
module pmul_ctrl #(
    parameter int MAX_TERMS = pmul_pkg::DEF_MAX_TERMS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_op,
    input  logic                         s_last,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pmul_pkg::TERM_W-1:0]  term_index,
    output logic                         last_term,
    output logic                         cap_exceeded,
    output pmul_pkg::pmul_cmd_t          cmd,
    output logic [$clog2(MAX_TERMS)-1:0] wr_addr,
    output logic [$clog2(MAX_TERMS)-1:0] rd_addr_a,
    output logic [$clog2(MAX_TERMS)-1:0] rd_addr_b,
    input  logic                         term_done
);

    import pmul_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int KW    = $clog2(2 * MAX_TERMS);

    pmul_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic             dropped_reg, dropped_next;
    logic [KW-1:0]    n_reg, n_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    i_reg, i_next;
    logic [KW-1:0]    i_hi_reg, i_hi_next;
    logic             first_reg, first_next;

    logic             accept;
    logic             a_full, b_full;
    logic             empty;
    logic [KW-1:0]    na, nb;
    logic [KW-1:0]    i_lo, i_hi;
    logic [KW-1:0]    diff;
    logic             pair_last;
    logic             final_term;

    assign accept     = s_valid & s_ready;
    assign a_full     = cnt_a_reg == CNT_W'(MAX_TERMS);
    assign b_full     = cnt_b_reg == CNT_W'(MAX_TERMS);
    assign na         = KW'(cnt_a_reg);
    assign nb         = KW'(cnt_b_reg);
    assign empty      = (cnt_a_reg == '0) || (cnt_b_reg == '0);
    assign i_lo       = (k_reg >= nb) ? (k_reg - nb + KW'(1)) : '0;
    assign i_hi       = (k_reg < na) ? k_reg : (na - KW'(1));
    assign diff       = k_reg - i_reg;
    assign pair_last  = i_reg == i_hi_reg;
    assign final_term = k_reg == (n_reg - KW'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_op == OP_SECOND && s_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = empty ? ST_OUT : ST_SETUP;
            end
            ST_SETUP: begin
                state_next = ST_MAC;
            end
            ST_MAC: begin
                if (pair_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (term_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = final_term ? ST_IDLE : ST_SETUP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                // ready is high here, so a valid word is taken
                s_ready  = 1'b1;
                cmd.wr_a = s_valid && s_op == OP_FIRST && !a_full;
                cmd.wr_b = s_valid && s_op == OP_SECOND && !b_full;
            end
            ST_START: begin
                cmd.load_zero = empty;
            end
            ST_MAC: begin
                cmd.rd    = 1'b1;
                cmd.first = first_reg;
                cmd.last  = pair_last;
            end
            ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign wr_addr      = (s_op == OP_SECOND) ? cnt_b_reg[$clog2(MAX_TERMS)-1:0]
                                              : cnt_a_reg[$clog2(MAX_TERMS)-1:0];
    assign rd_addr_a    = i_reg[$clog2(MAX_TERMS)-1:0];
    assign rd_addr_b    = diff[$clog2(MAX_TERMS)-1:0];
    assign term_index   = TERM_W'(k_reg);
    assign last_term    = final_term;
    assign cap_exceeded = dropped_reg;

    // counters and loop indexes
    always_comb begin
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        dropped_next = dropped_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        i_hi_next    = i_hi_reg;
        first_next   = first_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_FIRST) begin
                        if (a_full) begin
                            dropped_next = 1'b1;
                        end else begin
                            cnt_a_next = cnt_a_reg + CNT_W'(1);
                        end
                    end else begin
                        if (b_full) begin
                            dropped_next = 1'b1;
                        end else begin
                            cnt_b_next = cnt_b_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_START: begin
                n_next = empty ? KW'(1) : (na + nb - KW'(1));
                k_next = '0;
            end
            ST_SETUP: begin
                i_next     = i_lo;
                i_hi_next  = i_hi;
                first_next = 1'b1;
            end
            ST_MAC: begin
                i_next     = i_reg + KW'(1);
                first_next = 1'b0;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (final_term) begin
                        cnt_a_next   = '0;
                        cnt_b_next   = '0;
                        dropped_next = 1'b0;
                    end else begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        i_hi_reg  <= i_hi_next;
        first_reg <= first_next;
    end

endmodule

/* src/polynomial_multiply.sv */
// top level of the polynomial multiplier (coefficient convolution)
// depends on pmul_pkg, pmul_ctrl, pmul_dp and pmul_ram
//
// sequencing: loading words are taken while idle; after the word that closes the
// second operand, term k walks its m_k coefficient pairs through the single
// multiply-accumulate unit, then waits for its result word to be taken; a whole
// product has n = na + nb - 1 terms when neither operand is empty
// throughput: one word per cycle while loading, no words taken during a product
// reset: aresetn synchronous active low, clears counts, drop flag and control
module polynomial_multiply #(
    parameter int MAX_TERMS   = pmul_pkg::DEF_MAX_TERMS,
    parameter int COEFF_WIDTH = pmul_pkg::DEF_COEFF_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pmul_pkg::DATA_W-1:0]       s_axis_tdata,  // [31:0] coefficient
    input  logic                              s_axis_tuser,  // [0] operation
    input  logic                              s_axis_tlast,  // last coefficient
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] product_coefficient, [36:32] term_index, [39:37] zero
    output logic [pmul_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] capacity_exceeded
    output logic                              m_axis_tlast   // last_term
);

    import pmul_pkg::*;

    localparam int AW = $clog2(MAX_TERMS);

    pmul_cmd_t          cmd;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic               term_done;
    logic [TERM_W-1:0]  term_index;
    logic [DATA_W-1:0]  product_coefficient;

    // sequencing: loads operands, walks terms and coefficient pairs
    pmul_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_op         (s_axis_tuser),
        .s_last       (s_axis_tlast),
        .s_ready      (s_axis_tready),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .term_index   (term_index),
        .last_term    (m_axis_tlast),
        .cap_exceeded (m_axis_tuser),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .term_done    (term_done)
    );

    // stores, multiply, accumulate, shift and saturate; holds the result
    pmul_dp #(.MAX_TERMS(MAX_TERMS), .COEFF_WIDTH(COEFF_WIDTH)) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .wr_addr             (wr_addr),
        .rd_addr_a           (rd_addr_a),
        .rd_addr_b           (rd_addr_b),
        .wr_data             (s_axis_tdata[COEFF_WIDTH-1:0]),
        .term_done           (term_done),
        .product_coefficient (product_coefficient)
    );

    // result word packing, lowest field first
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, term_index, product_coefficient};

endmodule

/* dv/tb_polynomial_multiply.sv */
// self-checking testbench for polynomial_multiply: coefficient words in, product words out
// depends on pmul_pkg and polynomial_multiply; predicts each product term in plain sv
`timescale 1ns / 100ps

module tb_polynomial_multiply;
    import pmul_pkg::*;

    localparam int MAX_TERMS = pmul_pkg::DEF_MAX_TERMS;
    localparam int IDLE_PCT  = 19;
    localparam int HOLD_LEN  = 400;
    localparam int RAND_WORDS = 180;

    // saturation bounds of a signed q16.16 coefficient, in accumulator width
    localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

    typedef struct {
        logic        op;
        logic [31:0] coef;
        logic        last;
    } coef_word_t;

    typedef struct {
        logic [31:0]       value;
        logic [TERM_W-1:0] degree;
        logic              last;
        logic              dropped;
    } product_term_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;  // [31:0] coefficient
    logic                   s_axis_tuser  = 1'b0;  // [0] operation
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [31:0] coefficient, [36:32] degree, [39:37] zero
    logic                   m_axis_tuser;  // [0] capacity_exceeded
    logic                   m_axis_tlast;

    // words waiting to be offered, and product terms waiting to come out
    coef_word_t    pending_words[$];
    product_term_t expected_terms[$];

    // predictor copy of the operand stores
    logic signed [31:0] poly_a[MAX_TERMS];
    logic signed [31:0] poly_b[MAX_TERMS];
    int                 a_len = 0;
    int                 b_len = 0;
    logic               any_dropped = 1'b0;

    int   words_queued   = 0;
    int   words_accepted = 0;
    int   terms_seen     = 0;
    int   mismatch_count = 0;
    logic hold_armed     = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;

    polynomial_multiply dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // one convolution term: exact sum of q32.32 products, floor shift, saturate
    function automatic logic [31:0] conv_term(input int k);
        logic signed [71:0] acc;
        logic signed [71:0] scaled;
        longint             pp;
        int                 i;
        acc = '0;
        for (i = 0; i < a_len; i++) begin
            if (k - i >= 0 && k - i < b_len) begin
                pp  = longint'(poly_a[i]) * longint'(poly_b[k - i]);
                acc = acc + pp;
            end
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > SAT_HI) return 32'h7FFF_FFFF;
        if (scaled < SAT_LO) return 32'h8000_0000;
        return scaled[31:0];
    endfunction

    // update the operand stores with one accepted word, queue any product terms
    task automatic absorb_word(input logic op, input logic [31:0] coef, input logic last);
        product_term_t t;
        int            n;
        int            k;
        if (op == OP_FIRST) begin
            if (a_len < MAX_TERMS) begin
                poly_a[a_len] = coef;
                a_len++;
            end else begin
                any_dropped = 1'b1;
            end
        end else begin
            if (b_len < MAX_TERMS) begin
                poly_b[b_len] = coef;
                b_len++;
            end else begin
                any_dropped = 1'b1;
            end
            if (last) begin
                // an empty operand gives a lone zero term
                n = (a_len == 0 || b_len == 0) ? 1 : a_len + b_len - 1;
                for (k = 0; k < n; k++) begin
                    t.value   = (a_len == 0 || b_len == 0) ? 32'h0 : conv_term(k);
                    t.degree  = k[TERM_W-1:0];
                    t.last    = (k == n - 1);
                    t.dropped = any_dropped;
                    expected_terms = {expected_terms, t};
                end
                a_len       = 0;
                b_len       = 0;
                any_dropped = 1'b0;
            end
        end
    endtask

    task automatic push_word(input logic op, input logic [31:0] coef, input logic last);
        coef_word_t w;
        w.op   = op;
        w.coef = coef;
        w.last = last;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // mostly small q16.16 values so sums stay in range, with full-range and extremes mixed in
    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: begin
                return $urandom;
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            end
        endcase
    endfunction

    // one multiply: first and second operand words interleaved at random,
    // stray last flags on the first operand, closed by last on the second
    task automatic queue_product(input int na, input int nb);
        int fa;
        int fb;
        fa = na;
        fb = nb - 1;
        while (fa + fb > 0) begin
            if (fb == 0 || (fa > 0 && $urandom_range(0, 1) == 1)) begin
                push_word(OP_FIRST, rand_coeff(), $urandom_range(0, 3) == 0);
                fa--;
            end else begin
                push_word(OP_SECOND, rand_coeff(), 1'b0);
                fb--;
            end
        end
        push_word(OP_SECOND, rand_coeff(), 1'b1);
    endtask

    // wait until every offered word is taken and every expected term has come out
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_terms.size() != 0)
            @(posedge aclk);
    endtask

    // sender: predicts on acceptance, then offers the next word or idles
    always @(posedge aclk) begin : driver
        coef_word_t w;
        logic       calm;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_word(s_axis_tuser, s_axis_tdata, s_axis_tlast);
                words_accepted++;
            end
            // a stretch of back-to-back words with no idling
            calm = (words_accepted >= 90 && words_accepted < 150);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    w = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= w.coef;
                    s_axis_tuser  <= w.op;
                    s_axis_tlast  <= w.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off: once armed, the first result word starts a long stall
    always @(posedge aclk) begin : hold_off
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_armed && !hold_done && m_axis_tvalid) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: compares each accepted word with the oldest expected term
    always @(posedge aclk) begin : monitor
        product_term_t want;
        logic          calm;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                terms_seen++;
                if (expected_terms.size() == 0) begin
                    $error("unexpected result word: tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_terms.pop_front();
                    if (m_axis_tdata[DATA_W-1:0] !== want.value) begin
                        $error("product_coefficient: expected %h, got %h",
                               want.value, m_axis_tdata[DATA_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[DATA_W +: TERM_W] !== want.degree) begin
                        $error("term_index: expected %0d, got %0d",
                               want.degree, m_axis_tdata[DATA_W +: TERM_W]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
                        $error("tdata padding: expected 0, got %h",
                               m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_term: expected %b, got %b", want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.dropped) begin
                        $error("capacity_exceeded: expected %b, got %b",
                               want.dropped, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            calm = (terms_seen >= 60 && terms_seen < 120);
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty first operand: a single zero term
        push_word(OP_SECOND, 32'h0001_0000, 1'b1);
        // last on the first operand does not start anything
        push_word(OP_FIRST,  32'h0001_0000, 1'b1);
        push_word(OP_FIRST,  32'h0002_0000, 1'b0);
        push_word(OP_SECOND, 32'h0003_0000, 1'b0);
        push_word(OP_SECOND, 32'hFFFF_0000, 1'b1);
        // field extremes, saturating both ways
        push_word(OP_FIRST,  32'h7FFF_FFFF, 1'b0);
        push_word(OP_FIRST,  32'h8000_0000, 1'b0);
        push_word(OP_FIRST,  32'hFFFF_FFFF, 1'b0);
        push_word(OP_SECOND, 32'h7FFF_FFFF, 1'b0);
        push_word(OP_SECOND, 32'h8000_0000, 1'b1);
        // tiny fractions: the shift rounds toward minus infinity
        push_word(OP_FIRST,  32'h0000_0001, 1'b0);
        push_word(OP_FIRST,  32'hFFFF_FFFF, 1'b0);
        push_word(OP_SECOND, 32'h0000_0001, 1'b0);
        push_word(OP_SECOND, 32'h0000_8000, 1'b1);
        // all zero operands keep their terms
        push_word(OP_FIRST,  32'h0000_0000, 1'b0);
        push_word(OP_SECOND, 32'h0000_0000, 1'b1);
        // second operand words arriving ahead of the first
        push_word(OP_SECOND, 32'h0001_8000, 1'b0);
        push_word(OP_FIRST,  32'hFFFE_4000, 1'b0);
        push_word(OP_SECOND, 32'h0000_C000, 1'b1);

        // sender pauses until the directed part has fully drained
        wait_drained();
        @(posedge aclk);
        hold_armed <= 1'b1;

        // both stores overfilled: dropped words flagged, widest product,
        // and the receiver stall lands on it while more words queue behind
        queue_product(MAX_TERMS + 1, MAX_TERMS + 1);
        while (words_queued < RAND_WORDS) begin
            if ($urandom_range(0, 11) == 0)
                queue_product($urandom_range(12, MAX_TERMS + 2),
                              $urandom_range(12, MAX_TERMS + 2));
            else
                queue_product($urandom_range(0, 4), $urandom_range(1, 4));
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // generous limit well beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
